### sv/pcm_pkg.sv
`timescale 1ns / 1ps

package pcm_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_METRICS_DEF = 8;
   localparam int MAX_ROWS_DEF    = 4096;

   // Field widths of the stream and register words.
   localparam int MC_W       = 4;
   localparam int THR_W      = 15;
   localparam int SAMPLE_W   = 16;
   localparam int OUT_IDX_W  = 3;
   localparam int COEF_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_PAD_W  = 1;
   localparam int RSP_DATA_W = 2 * OUT_IDX_W + COEF_W + 1 + RSP_PAD_W;

   // Shared multiplier and the limb-serial wide product built on it.
   localparam int LIMB_W   = 32;
   localparam int OP_LIMBS = 4;
   localparam int OP_W     = LIMB_W * OP_LIMBS;
   localparam int ACC_W    = 2 * OP_W;
   localparam int MUL_W    = LIMB_W + 1;
   localparam int PROD_W   = 2 * MUL_W;

   // Register reset values and codes.
   localparam logic [MC_W-1:0]      METRIC_COUNT_RST     = 4'd8;
   localparam logic [THR_W-1:0]     THR_RST              = 15'd22938;
   localparam logic [COEF_W-1:0]    COEF_MAX             = 16'h7FFF;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_COUNT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRONG_THRESHOLD = 1'b1;
   localparam logic                 CMD_SAMPLE           = 1'b0;
   localparam logic                 CMD_FINISH           = 1'b1;
   localparam logic [STATUS_W-1:0]  STATUS_OK            = 2'd0;
   localparam logic [STATUS_W-1:0]  STATUS_FEW_ROWS      = 2'd1;
   localparam logic [STATUS_W-1:0]  STATUS_DROPPED       = 2'd2;
   localparam int                   MIN_ROWS             = 3;

   // One request to the shared signed multiplier.
   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_FIN_START,
      ST_VAR_RD,
      ST_VAR_M1,
      ST_VAR_M2,
      ST_VAR_WR,
      ST_PAIR_RD,
      ST_PAIR_M1,
      ST_PAIR_M2,
      ST_PAIR_NUM,
      ST_PAIR_ML,
      ST_TEST_INIT,
      ST_TEST_K,
      ST_TEST_T,
      ST_TEST_R,
      ST_TEST_CMP,
      ST_EMIT,
      ST_ERR,
      ST_CLEAR,
      ST_WAIT
   } state_type;

   // Position of pair (a, b), a <= b, in the packed upper triangle.
   function automatic int tri_index(int a, int b, int m);
      return ((a * (2 * m - a + 1)) >>> 1) + (b - a);
   endfunction

endpackage

### sv/pearson_correlation_matrix.sv
`timescale 1ns / 1ps
// A sample word goes into the row buffer; the word that completes a row starts a commit
// of one product per pair (a, b), a <= b, through the shared multiplier, during which
// req_tready is low; a row beyond MAX_ROWS is dropped instead. In a finish word,
// each wide product is 16 limb steps of the one 33x33 multiplier, and r is found by
// a bit search of up to 16 steps, three wide products each. Results go out one per pair.
// Reset is synchronous and clears sums, counts and registers at once; no clearing pass.

module pearson_correlation_matrix import pcm_pkg::*; #(
   parameter int MAX_METRICS = MAX_METRICS_DEF,
   parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] sample_value
   input  logic [0:0]            req_tuser,  // [0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [2:0] first_idx, [5:3] second_idx,
                                             // [21:6] coefficient, [22] strong_res
   output logic [STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(MAX_METRICS);
   localparam int TRI_N  = MAX_METRICS * (MAX_METRICS + 1) / 2;
   localparam int ADDR_W = $clog2(TRI_N);
   localparam int RC_W   = $clog2(MAX_ROWS + 1);
   localparam int SUM_W  = SAMPLE_W + RC_W;
   localparam int PSUM_W = 2 * SAMPLE_W + RC_W;
   localparam int VAR_W  = 2 * RC_W + 2 * SAMPLE_W - 1;
   localparam int NUM_W  = VAR_W + 1;

   state_type state_ff, state_in, ret_ff;

   logic [MC_W-1:0]  metric_count_ff;
   logic [THR_W-1:0] thr_ff;
   logic [MC_W-1:0]  m_eff;
   logic [IDX_W-1:0] m_last, m_pen;

   logic signed [SAMPLE_W-1:0] rb_ff [MAX_METRICS];
   logic signed [SAMPLE_W-1:0] rb_rd, xa_ff;
   logic [IDX_W-1:0]           col_ff;
   logic [RC_W-1:0]            row_count_ff;
   logic                       dropped_ff;
   logic signed [SUM_W-1:0]    msum_ff [MAX_METRICS];
   logic signed [SUM_W-1:0]    msum_rd, sa_ff;
   logic [SUM_W-1:0]           abs_ms, abs_sa;

   logic signed [PSUM_W-1:0] psum_mem [TRI_N];
   logic [TRI_N-1:0]         pvalid_ff;
   logic signed [PSUM_W-1:0] rd_ff;
   logic [PSUM_W-1:0]        abs_rd;
   logic [ADDR_W-1:0]        rd_addr, waddr_ff;
   logic                     wr_pend_ff;

   logic [IDX_W-1:0] a_ff, b_ff;
   logic [VAR_W-1:0] var_ff [MAX_METRICS];
   logic [VAR_W-1:0] var_rd;
   logic [MAX_METRICS-1:0] var_zero_ff;
   logic [VAR_W-1:0] nprod_ff, mag_ff;
   logic             sab_neg_ff, sv_neg_ff, num_neg_ff;
   logic signed [NUM_W-1:0] pu, pv, num;
   logic [ACC_W-1:0] l_ff;
   logic [COEF_W-1:0] q_ff, cand, q_cl, coef;
   logic [3:0]        bit_ff;
   logic [COEF_W:0]   k_w;
   logic              ge, test_end, num_skip;

   logic req_acc, is_sample, row_done, slot_free, last_pair, rsp_load;
   logic bm_start, bm_done;
   logic [OP_W-1:0]  bm_x, bm_y, n_op;
   logic [ACC_W-1:0] acc;
   mul_req_type bm_req, cmt_req, mul_req;
   logic signed [PROD_W-1:0] prod;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Effective metric count, clamped to the supported range.
   always_comb begin
      m_eff = metric_count_ff;
      if (m_eff < MC_W'(2)) begin
         m_eff = MC_W'(2);
      end
      if (m_eff > MC_W'(MAX_METRICS)) begin
         m_eff = MC_W'(MAX_METRICS);
      end
   end
   assign m_last = IDX_W'(m_eff - MC_W'(1));
   assign m_pen  = IDX_W'(m_eff - MC_W'(2));

   assign req_acc   = req_tvalid && req_tready;
   assign is_sample = (req_tuser[0] == CMD_SAMPLE);
   assign row_done  = (MC_W'(col_ff) + MC_W'(1)) >= m_eff;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign last_pair = (a_ff == m_pen) && (b_ff == m_last);
   assign csr_ready = 1'b1;
   assign n_op      = OP_W'(row_count_ff);

   // Read ports of the small register arrays.
   assign rb_rd   = rb_ff[b_ff];
   assign msum_rd = msum_ff[(state_ff == ST_PAIR_M2) ? b_ff : a_ff];
   assign var_rd  = var_ff[(state_ff == ST_TEST_R) ? b_ff : a_ff];
   assign abs_ms  = msum_rd[SUM_W-1] ? SUM_W'(-msum_rd) : SUM_W'(msum_rd);
   assign abs_sa  = sa_ff[SUM_W-1] ? SUM_W'(-sa_ff) : SUM_W'(sa_ff);
   assign abs_rd  = rd_ff[PSUM_W-1] ? PSUM_W'(-rd_ff) : PSUM_W'(rd_ff);
   assign rd_addr = ADDR_W'(tri_index(int'(a_ff),
                       int'((state_ff == ST_VAR_RD) ? a_ff : b_ff), MAX_METRICS));

   // Numerator N*Sab - Sa*Sb from the two magnitudes and their signs.
   assign pu  = sab_neg_ff ? -$signed({1'b0, nprod_ff}) : $signed({1'b0, nprod_ff});
   assign pv  = sv_neg_ff ? -$signed({1'b0, acc[VAR_W-1:0]}) : $signed({1'b0, acc[VAR_W-1:0]});
   assign num = pu - pv;
   assign num_skip = (num == '0) || var_zero_ff[a_ff] || var_zero_ff[b_ff];

   // Bit search for the Q15 magnitude: (2q-1)^2 * va * vb <= num^2 * 2^32.
   assign cand     = q_ff | (COEF_W'(1) << bit_ff);
   assign k_w      = {cand, 1'b0} - (COEF_W + 1)'(1);
   assign ge       = l_ff >= acc;
   assign test_end = (bit_ff == 4'd0) || ((bit_ff == 4'd15) && ge);
   assign q_cl     = (q_ff > COEF_MAX) ? COEF_MAX : q_ff;
   assign coef     = num_neg_ff ? -q_cl : q_cl;

   // Commit products: the held x_a times the buffered x_b.
   assign cmt_req.a = MUL_W'((b_ff == a_ff) ? rb_rd : xa_ff);
   assign cmt_req.b = MUL_W'(rb_rd);
   assign mul_req   = (state_ff == ST_COMMIT) ? cmt_req : bm_req;

   pcm_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .prod_ff (prod)
   );

   pcm_bigmul u_bigmul (
      .clock   (clock),
      .reset   (reset),
      .start   (bm_start),
      .x       (bm_x),
      .y       (bm_y),
      .mul_req (bm_req),
      .prod    (prod),
      .done    (bm_done),
      .acc_ff  (acc)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!is_sample) begin
                  state_in = ST_FIN_START;
               end else if (row_done && (row_count_ff < RC_W'(MAX_ROWS))) begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_COMMIT: begin
            if ((a_ff == m_last) && (b_ff == m_last)) begin
               state_in = ST_IDLE;
            end
         end
         ST_FIN_START: begin
            state_in = (row_count_ff < RC_W'(MIN_ROWS)) ? ST_ERR : ST_VAR_RD;
         end
         ST_VAR_RD:    state_in = ST_VAR_M1;
         ST_VAR_M1:    state_in = ST_WAIT;
         ST_VAR_M2:    state_in = ST_WAIT;
         ST_VAR_WR:    state_in = (a_ff == m_last) ? ST_PAIR_RD : ST_VAR_RD;
         ST_PAIR_RD:   state_in = ST_PAIR_M1;
         ST_PAIR_M1:   state_in = ST_WAIT;
         ST_PAIR_M2:   state_in = ST_WAIT;
         ST_PAIR_NUM:  state_in = num_skip ? ST_EMIT : ST_PAIR_ML;
         ST_PAIR_ML:   state_in = ST_WAIT;
         ST_TEST_INIT: state_in = ST_TEST_K;
         ST_TEST_K:    state_in = ST_WAIT;
         ST_TEST_T:    state_in = ST_WAIT;
         ST_TEST_R:    state_in = ST_WAIT;
         ST_TEST_CMP:  state_in = test_end ? ST_EMIT : ST_TEST_K;
         ST_EMIT: begin
            if (slot_free) begin
               state_in = last_pair ? ST_CLEAR : ST_PAIR_RD;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR:     state_in = ST_IDLE;
         ST_WAIT: begin
            if (bm_done) begin
               state_in = ret_ff;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and wide-product requests.
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      bm_start   = 1'b0;
      bm_x       = '0;
      bm_y       = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_VAR_M1: begin
            bm_start = 1'b1;
            bm_x     = n_op;
            bm_y     = OP_W'(abs_rd);
         end
         ST_VAR_M2: begin
            bm_start = 1'b1;
            bm_x     = OP_W'(abs_ms);
            bm_y     = OP_W'(abs_ms);
         end
         ST_PAIR_M1: begin
            bm_start = 1'b1;
            bm_x     = n_op;
            bm_y     = OP_W'(abs_rd);
         end
         ST_PAIR_M2: begin
            bm_start = 1'b1;
            bm_x     = OP_W'(abs_sa);
            bm_y     = OP_W'(abs_ms);
         end
         ST_PAIR_ML: begin
            bm_start = 1'b1;
            bm_x     = OP_W'(mag_ff);
            bm_y     = OP_W'(mag_ff);
         end
         ST_TEST_K: begin
            bm_start = 1'b1;
            bm_x     = OP_W'(k_w[COEF_W-1:0]);
            bm_y     = OP_W'(k_w[COEF_W-1:0]);
         end
         ST_TEST_T, ST_TEST_R: begin
            bm_start = 1'b1;
            bm_x     = acc[OP_W-1:0];
            bm_y     = OP_W'(var_rd);
         end
         ST_EMIT, ST_ERR: rsp_load = slot_free;
         default: begin
         end
      endcase
   end

   // Result word for the current pair, or the error word.
   always_comb begin
      if (state_ff == ST_ERR) begin
         rsp_data_in = '0;
         rsp_user_in = STATUS_FEW_ROWS;
         rsp_last_in = 1'b1;
      end else begin
         rsp_data_in = {{RSP_PAD_W{1'b0}}, (q_cl > COEF_W'(thr_ff)), coef,
                        OUT_IDX_W'(b_ff), OUT_IDX_W'(a_ff)};
         rsp_user_in = dropped_ff ? STATUS_DROPPED : STATUS_OK;
         rsp_last_in = last_pair;
      end
   end

   // Control state: registers, counters, sums and valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         metric_count_ff <= METRIC_COUNT_RST;
         thr_ff          <= THR_RST;
         col_ff          <= '0;
         row_count_ff    <= '0;
         dropped_ff      <= 1'b0;
         pvalid_ff       <= '0;
         wr_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         a_ff            <= '0;
         b_ff            <= '0;
         for (int i = 0; i < MAX_METRICS; i++) begin
            msum_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         wr_pend_ff <= (state_ff == ST_COMMIT);
         if (wr_pend_ff) begin
            pvalid_ff[waddr_ff] <= 1'b1;
         end

         // Sample words fill the row buffer.
         if (req_acc && is_sample) begin
            col_ff <= row_done ? '0 : col_ff + IDX_W'(1);
            if (row_done) begin
               a_ff <= '0;
               b_ff <= '0;
               if (row_count_ff < RC_W'(MAX_ROWS)) begin
                  row_count_ff <= row_count_ff + RC_W'(1);
               end else begin
                  dropped_ff <= 1'b1;
               end
            end
         end

         unique case (state_ff)
            ST_COMMIT: begin
               if (b_ff == a_ff) begin
                  msum_ff[a_ff] <= msum_ff[a_ff] + SUM_W'(rb_rd);
               end
               if (b_ff == m_last) begin
                  a_ff <= a_ff + IDX_W'(1);
                  b_ff <= a_ff + IDX_W'(1);
               end else begin
                  b_ff <= b_ff + IDX_W'(1);
               end
            end
            ST_FIN_START: a_ff <= '0;
            ST_VAR_WR: begin
               if (a_ff == m_last) begin
                  a_ff <= '0;
                  b_ff <= IDX_W'(1);
               end else begin
                  a_ff <= a_ff + IDX_W'(1);
               end
            end
            ST_EMIT: begin
               if (slot_free && !last_pair) begin
                  if (b_ff == m_last) begin
                     a_ff <= a_ff + IDX_W'(1);
                     b_ff <= a_ff + IDX_W'(2);
                  end else begin
                     b_ff <= b_ff + IDX_W'(1);
                  end
               end
            end
            ST_CLEAR: begin
               col_ff       <= '0;
               row_count_ff <= '0;
               dropped_ff   <= 1'b0;
               pvalid_ff    <= '0;
               for (int i = 0; i < MAX_METRICS; i++) begin
                  msum_ff[i] <= '0;
               end
            end
            default: begin
            end
         endcase

         // Register writes.
         if (csr_valid) begin
            unique case (csr_index)
               CSR_METRIC_COUNT: begin
                  metric_count_ff <= csr_data[MC_W-1:0];
                  col_ff          <= '0;
               end
               CSR_STRONG_THRESHOLD: thr_ff <= csr_data[THR_W-1:0];
               default: begin
               end
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Product-sum memory: registered read, write in the cycle after the read.
   always_ff @(posedge clock) begin
      rd_ff    <= pvalid_ff[rd_addr] ? psum_mem[rd_addr] : '0;
      waddr_ff <= rd_addr;
      if (wr_pend_ff) begin
         psum_mem[waddr_ff] <= rd_ff + prod[PSUM_W-1:0];
      end
   end

   // Datapath registers: row buffer, commit operand, response word and finish computation.
   always_ff @(posedge clock) begin
      if (req_acc && is_sample) begin
         rb_ff[col_ff] <= $signed(req_tdata);
      end
      if ((state_ff == ST_COMMIT) && (b_ff == a_ff)) begin
         xa_ff <= rb_rd;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
      case (state_ff)
         ST_VAR_M1:  ret_ff <= ST_VAR_M2;
         ST_VAR_M2: begin
            ret_ff   <= ST_VAR_WR;
            nprod_ff <= acc[VAR_W-1:0];
         end
         ST_VAR_WR: begin
            var_ff[a_ff]      <= nprod_ff - acc[VAR_W-1:0];
            var_zero_ff[a_ff] <= (nprod_ff == acc[VAR_W-1:0]);
         end
         ST_PAIR_M1: begin
            ret_ff     <= ST_PAIR_M2;
            sab_neg_ff <= rd_ff[PSUM_W-1];
            sa_ff      <= msum_rd;
         end
         ST_PAIR_M2: begin
            ret_ff    <= ST_PAIR_NUM;
            nprod_ff  <= acc[VAR_W-1:0];
            sv_neg_ff <= sa_ff[SUM_W-1] ^ msum_rd[SUM_W-1];
         end
         ST_PAIR_NUM: begin
            num_neg_ff <= num[NUM_W-1];
            mag_ff     <= num[NUM_W-1] ? VAR_W'(-num) : VAR_W'(num);
            q_ff       <= '0;
         end
         ST_PAIR_ML: ret_ff <= ST_TEST_INIT;
         ST_TEST_INIT: begin
            l_ff   <= acc << LIMB_W;
            q_ff   <= '0;
            bit_ff <= 4'd15;
         end
         ST_TEST_K: ret_ff <= ST_TEST_T;
         ST_TEST_T: ret_ff <= ST_TEST_R;
         ST_TEST_R: ret_ff <= ST_TEST_CMP;
         ST_TEST_CMP: begin
            if (ge) begin
               q_ff <= cand;
            end
            bit_ff <= bit_ff - 4'd1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/pcm_mul.sv
`timescale 1ns / 1ps

module pcm_mul import pcm_pkg::*; (
   input  logic                     clock,
   input  mul_req_type              req,
   output logic signed [PROD_W-1:0] prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // Signed multiply with a registered product.
   assign prod_in = req.a * req.b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### sv/pcm_bigmul.sv
`timescale 1ns / 1ps

module pcm_bigmul import pcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OP_W-1:0]          x,
   input  logic [OP_W-1:0]          y,
   output mul_req_type              mul_req,
   input  logic signed [PROD_W-1:0] prod,
   output logic                     done,
   output logic [ACC_W-1:0]         acc_ff
);

   localparam int STEPS  = OP_LIMBS * OP_LIMBS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int LIDX_W = $clog2(OP_LIMBS);
   localparam int SH_W   = $clog2(2 * OP_LIMBS - 1);

   logic [OP_W-1:0]   x_ff, y_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff, pend_ff;
   logic [SH_W-1:0]   sh_ff;
   logic [LIDX_W-1:0] li, lj;
   logic              issue;
   logic [ACC_W-1:0]  addend;

   // Step counter walks every limb pair of the two operands.
   assign li    = step_ff[2*LIDX_W-1:LIDX_W];
   assign lj    = step_ff[LIDX_W-1:0];
   assign issue = run_ff && (step_ff < STEP_W'(STEPS));
   assign done  = run_ff && (step_ff == STEP_W'(STEPS));

   assign mul_req.a = $signed({1'b0, x_ff[li*LIMB_W +: LIMB_W]});
   assign mul_req.b = $signed({1'b0, y_ff[lj*LIMB_W +: LIMB_W]});

   // Partial product placed at its limb offset.
   assign addend = ACC_W'(prod[2*LIMB_W-1:0]) << (sh_ff * LIMB_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         pend_ff <= 1'b0;
         step_ff <= '0;
      end else if (run_ff) begin
         if (done) begin
            run_ff <= 1'b0;
         end
         pend_ff <= issue;
         if (issue) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // Operands, offset and accumulator.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         y_ff   <= y;
         acc_ff <= '0;
      end else if (run_ff) begin
         if (issue) begin
            sh_ff <= SH_W'(li) + SH_W'(lj);
         end
         if (pend_ff) begin
            acc_ff <= acc_ff + addend;
         end
      end
   end

endmodule
